// ===== rtl/core/lfhs_pkg.sv =====
package lfhs_pkg;

    // Heat store depth and the range of strip lengths in use.
    localparam int MAX_CELLS = 256;
    localparam int LEN_MIN   = 8;
    localparam int LEN_MAX   = (MAX_CELLS < 256) ? MAX_CELLS : 256;

    // Request queue between the front and back parts.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // Reset values of the configuration registers.
    localparam logic [7:0] COOLING_RST = 8'd55;
    localparam logic [7:0] CHANCE_RST  = 8'd120;
    localparam logic [8:0] LENGTH_RST  = 9'd60;

    // Arithmetic constants of the fire simulation.
    localparam logic [11:0] COOL_GAIN   = 12'd10;
    localparam logic [7:0]  SPAN_OFFSET = 8'd2;
    localparam logic [7:0]  HEAT_SAT    = 8'd255;
    localparam logic [15:0] SPARK_CELLS = 16'd7;
    localparam logic [15:0] SPARK_RANGE = 16'd95;
    localparam logic [7:0]  SPARK_BASE  = 8'd160;
    localparam logic [15:0] COLOR_GAIN  = 16'd241;
    localparam logic [19:0] RECIP_THIRD = 20'd683;

    // Configuration register indexes.
    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_COOLING = 2'd0;
    localparam t_cfg_idx CFG_CHANCE  = 2'd1;
    localparam t_cfg_idx CFG_LENGTH  = 2'd2;
    localparam t_cfg_idx CFG_REVERSE = 2'd3;

    // One classified cell request as it travels from front to back.
    typedef struct packed {
        logic [7:0] cell_idx;
        logic [7:0] cool;
        logic       spark_hit;
        logic [7:0] spark_amt;
        logic [7:0] pixel;
        logic       last;
    } t_item;

    // Strip length clamped to the supported range.
    function automatic logic [8:0] used_length(input logic [8:0] len);
        logic [8:0] res;
        res = len;
        if (len < 9'(LEN_MIN)) begin
            res = 9'(LEN_MIN);
        end else if (len > 9'(LEN_MAX)) begin
            res = 9'(LEN_MAX);
        end
        return res;
    endfunction

    // Floor of x / 3 for x below 768, by a reciprocal multiply.
    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [19:0] prod;
        prod = 20'(x) * RECIP_THIRD;
        return prod[18:11];
    endfunction

endpackage

// ===== rtl/core/lfhs_span_div.sv =====
module lfhs_span_div (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [7:0] i_cooling,
    input  logic [8:0] i_length,
    output logic [7:0] o_span,
    output logic       o_span_ok
);
    import lfhs_pkg::*;

    localparam int DIV_W = 12;
    localparam int CNT_W = $clog2(DIV_W);

    typedef enum logic [2:0] {
        DIV_LOAD = 3'b001,
        DIV_RUN  = 3'b010,
        DIV_DONE = 3'b100
    } t_div_state;

    t_div_state         r_state;
    logic [CNT_W-1:0]   r_cnt;
    logic [DIV_W-1:0]   r_quo;
    logic [8:0]         r_rem;
    logic [9:0]         n_trial;
    logic               n_ge;
    logic [9:0]         n_rem;

    // One restoring division step per cycle: shift in a dividend bit, try the subtract.
    always_comb begin
        n_trial = {r_rem, r_quo[DIV_W-1]};
        n_ge    = n_trial >= {1'b0, i_length};
        n_rem   = n_ge ? (n_trial - {1'b0, i_length}) : n_trial;
    end

    // Sequencer: any configuration write restarts the division.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DIV_LOAD;
            r_cnt   <= '0;
        end else if (i_start) begin
            r_state <= DIV_LOAD;
        end else begin
            unique case (r_state)
                DIV_LOAD: begin
                    r_cnt   <= '0;
                    r_state <= DIV_RUN;
                end
                DIV_RUN: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(DIV_W - 1)) begin
                        r_state <= DIV_DONE;
                    end
                end
                DIV_DONE: begin
                    r_state <= DIV_DONE;
                end
                default: begin
                    r_state <= DIV_LOAD;
                end
            endcase
        end
    end

    // Dividend and remainder registers.
    always_ff @(posedge i_clk) begin
        if (r_state == DIV_LOAD) begin
            r_quo <= {4'b0, i_cooling} * COOL_GAIN;
            r_rem <= '0;
        end else if (r_state == DIV_RUN) begin
            r_quo <= {r_quo[DIV_W-2:0], n_ge};
            r_rem <= n_rem[8:0];
        end
    end

    // Span is the quotient plus two, saturated to one byte.
    assign o_span    = (r_quo > DIV_W'(HEAT_SAT - SPAN_OFFSET)) ? HEAT_SAT
                                                               : r_quo[7:0] + SPAN_OFFSET;
    assign o_span_ok = (r_state == DIV_DONE);

endmodule

// ===== rtl/core/lfhs_front.sv =====
module lfhs_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [7:0]          i_cool_draw,
    input  logic [7:0]          i_spark_chance_draw,
    input  logic [7:0]          i_spark_cell_draw,
    input  logic [7:0]          i_spark_heat_draw,
    input  logic [7:0]          i_spark_chance,
    input  logic [8:0]          i_length,
    input  logic                i_reverse,
    input  logic [7:0]          i_span,
    input  logic                i_span_ok,
    input  logic                i_q_full,
    output logic                o_push,
    output lfhs_pkg::t_item     o_item
);
    import lfhs_pkg::*;

    logic [7:0]  r_cell;
    logic        r_spark_en;
    logic [2:0]  r_spark_cell;
    logic [7:0]  r_spark_amt;

    logic        n_first;
    logic        n_spark_en;
    logic [2:0]  n_spark_cell;
    logic [7:0]  n_spark_amt;
    logic [15:0] n_cell_prod;
    logic [15:0] n_heat_prod;
    logic [15:0] n_cool_prod;
    logic [8:0]  n_len_m1;
    logic [8:0]  n_rev;
    logic        n_last;

    assign o_in_ready = i_span_ok && !i_q_full;
    assign o_push     = i_in_valid && o_in_ready;

    // The first cell of a frame draws a new spark; later cells reuse it.
    always_comb begin
        n_first      = (r_cell == '0);
        n_cell_prod  = 16'(i_spark_cell_draw) * SPARK_CELLS;
        n_heat_prod  = 16'(i_spark_heat_draw) * SPARK_RANGE;
        n_spark_en   = n_first ? (i_spark_chance_draw < i_spark_chance) : r_spark_en;
        n_spark_cell = n_first ? n_cell_prod[10:8] : r_spark_cell;
        n_spark_amt  = n_first ? (SPARK_BASE + n_heat_prod[15:8]) : r_spark_amt;
    end

    // Cooling amount, frame position and pixel mapping of this cell.
    always_comb begin
        n_cool_prod = 16'(i_cool_draw) * 16'(i_span);
        n_len_m1    = i_length - 9'd1;
        n_rev       = n_len_m1 - {1'b0, r_cell};
        n_last      = {1'b0, r_cell} >= n_len_m1;

        o_item.cell_idx  = r_cell;
        o_item.cool      = n_cool_prod[15:8];
        o_item.spark_hit = n_spark_en && (r_cell == {5'b0, n_spark_cell});
        o_item.spark_amt = n_spark_amt;
        o_item.pixel     = i_reverse ? n_rev[7:0] : r_cell;
        o_item.last      = n_last;
    end

    // Cell counter and spark state advance on each accepted request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell       <= '0;
            r_spark_en   <= 1'b0;
            r_spark_cell <= '0;
            r_spark_amt  <= '0;
        end else if (o_push) begin
            r_cell       <= n_last ? 8'd0 : r_cell + 8'd1;
            r_spark_en   <= n_spark_en;
            r_spark_cell <= n_spark_cell;
            r_spark_amt  <= n_spark_amt;
        end
    end

endmodule

// ===== rtl/core/lfhs_queue.sv =====
module lfhs_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  lfhs_pkg::t_item     i_item,
    input  logic                i_pop,
    output lfhs_pkg::t_item     o_head,
    output logic                o_empty,
    output logic                o_full
);
    import lfhs_pkg::*;

    t_item              r_slot [QDEPTH];
    logic [QPTR_W-1:0]  r_wr;
    logic [QPTR_W-1:0]  r_rd;
    logic [QPTR_W:0]    r_cnt;

    assign o_head  = r_slot[r_rd];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (QPTR_W + 1)'(QDEPTH));

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_item;
        end
    end

endmodule

// ===== rtl/core/lfhs_back.sv =====
module lfhs_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_empty,
    input  lfhs_pkg::t_item     i_head,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [7:0]          o_pixel_index,
    output logic [7:0]          o_color_index,
    output logic                o_frame_end
);
    import lfhs_pkg::*;

    // Heat store with a written flag per cell; an unwritten cell reads as zero.
    logic [7:0]            r_heat_mem [MAX_CELLS];
    logic [MAX_CELLS-1:0]  r_heat_vld;

    logic        n_adv;

    // Read stage.
    logic        r_a_valid;
    t_item       r_a;
    logic [7:0]  r_a_raw;
    logic        r_a_hv;

    // Update stage.
    logic        r_b_valid;
    logic [7:0]  r_b_fresh;
    logic [7:0]  r_b_pixel;
    logic        r_b_last;

    // Output register.
    logic        r_out_valid;
    logic [7:0]  r_pixel;
    logic [7:0]  r_color;
    logic        r_last;

    // Cooled heat of the two previous cells.
    logic [7:0]  r_prev1;
    logic [7:0]  r_prev2;

    logic [7:0]  n_heat;
    logic [7:0]  n_cooled;
    logic [9:0]  n_sum;
    logic [7:0]  n_base;
    logic [8:0]  n_spk;
    logic [7:0]  n_fresh;
    logic [15:0] n_color_prod;

    // The whole pipeline moves when the output register is free or being emptied.
    assign n_adv = !r_out_valid || i_out_ready;
    assign o_pop = n_adv && !i_q_empty;

    // Cool, diffuse and spark the cell held in the read stage.
    always_comb begin
        n_heat   = r_a_hv ? r_a_raw : 8'd0;
        n_cooled = (n_heat > r_a.cool) ? (n_heat - r_a.cool) : 8'd0;
        n_sum    = {2'b0, r_prev1} + {1'b0, r_prev2, 1'b0};
        n_base   = (r_a.cell_idx >= 8'd2) ? div3(n_sum) : n_cooled;
        n_spk    = {1'b0, n_base} + {1'b0, r_a.spark_amt};
        if (r_a.spark_hit) begin
            n_fresh = n_spk[8] ? HEAT_SAT : n_spk[7:0];
        end else begin
            n_fresh = n_base;
        end
        n_color_prod = 16'(r_b_fresh) * COLOR_GAIN;
    end

    // Heat store: read the next cell while the current one is written back.
    always_ff @(posedge i_clk) begin
        if (n_adv && r_a_valid) begin
            r_heat_mem[r_a.cell_idx] <= n_fresh;
        end
        if (o_pop) begin
            r_a_raw <= r_heat_mem[i_head.cell_idx];
        end
    end

    // Control state of the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heat_vld  <= '0;
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_prev1     <= '0;
            r_prev2     <= '0;
        end else if (n_adv) begin
            r_a_valid   <= !i_q_empty;
            r_b_valid   <= r_a_valid;
            r_out_valid <= r_b_valid;
            if (r_a_valid) begin
                r_heat_vld[r_a.cell_idx] <= 1'b1;
                r_prev2                  <= r_prev1;
                r_prev1                  <= n_cooled;
            end
        end
    end

    // Payload registers of the pipeline.
    always_ff @(posedge i_clk) begin
        if (n_adv) begin
            if (o_pop) begin
                r_a    <= i_head;
                r_a_hv <= r_heat_vld[i_head.cell_idx];
            end
            r_b_fresh <= n_fresh;
            r_b_pixel <= r_a.pixel;
            r_b_last  <= r_a.last;
            r_pixel   <= r_b_pixel;
            r_color   <= n_color_prod[15:8];
            r_last    <= r_b_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_index = r_pixel;
    assign o_color_index = r_color;
    assign o_frame_end   = r_last;

endmodule

// ===== rtl/core/led_fire_heat_simulation.sv =====
// One-dimensional LED fire heat simulation, streamed one cell per request.
// Input channel (i_in_valid / o_in_ready) takes one request per cell, cells
// 0 to length-1 of each frame in order, each with four raw random bytes.
// Output channel (o_out_valid / i_out_ready) returns one result per request:
// pixel index, palette index of the new heat and a mark on the frame's last cell.
// A request passes the queue, read stage, update stage and output register.
// Throughput is one cell per clock while the span is ready and nothing stalls:
// the front part classifies a cell and computes its cooling amount, a four-entry
// queue holds it, and the back part does the heat store read-modify-write in a
// read stage and an update stage. Configuration is to be written via i_cfg_we /
// i_cfg_index / i_cfg_data only while idle, which binds the user; the block does
// not enforce it. Every write restarts the cooling span divider (cooling*10 /
// length, one quotient bit per cycle), which holds o_in_ready low until done.
// Reset is synchronous and active low; it restores the register defaults, marks
// every heat cell as zero and runs the divider once before the first request is
// taken. On a receiver stall the output register holds its result, the pipeline
// freezes and the queue absorbs up to four more requests before o_in_ready falls.
module led_fire_heat_simulation (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_cool_draw,
    input  logic [7:0]  i_spark_chance_draw,
    input  logic [7:0]  i_spark_cell_draw,
    input  logic [7:0]  i_spark_heat_draw,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_pixel_index,
    output logic [7:0]  o_color_index,
    output logic        o_frame_end,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data
);
    import lfhs_pkg::*;

    logic [7:0]  r_cooling;
    logic [7:0]  r_spark_chance;
    logic [8:0]  r_strip_length;
    logic        r_reverse;

    logic [8:0]  n_length;
    logic [7:0]  n_span;
    logic        n_span_ok;
    logic        n_push;
    t_item       n_item;
    t_item       n_head;
    logic        n_pop;
    logic        n_q_empty;
    logic        n_q_full;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cooling      <= COOLING_RST;
            r_spark_chance <= CHANCE_RST;
            r_strip_length <= LENGTH_RST;
            r_reverse      <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_COOLING: r_cooling      <= i_cfg_data[7:0];
                CFG_CHANCE:  r_spark_chance <= i_cfg_data[7:0];
                CFG_LENGTH:  r_strip_length <= i_cfg_data;
                CFG_REVERSE: r_reverse      <= i_cfg_data[0];
                default:     r_reverse      <= r_reverse;
            endcase
        end
    end

    assign n_length = used_length(r_strip_length);

    lfhs_span_div u_span_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cfg_we),
        .i_cooling (r_cooling),
        .i_length  (n_length),
        .o_span    (n_span),
        .o_span_ok (n_span_ok)
    );

    lfhs_front u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_cool_draw         (i_cool_draw),
        .i_spark_chance_draw (i_spark_chance_draw),
        .i_spark_cell_draw   (i_spark_cell_draw),
        .i_spark_heat_draw   (i_spark_heat_draw),
        .i_spark_chance      (r_spark_chance),
        .i_length            (n_length),
        .i_reverse           (r_reverse),
        .i_span              (n_span),
        .i_span_ok           (n_span_ok),
        .i_q_full            (n_q_full),
        .o_push              (n_push),
        .o_item              (n_item)
    );

    lfhs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (n_push),
        .i_item  (n_item),
        .i_pop   (n_pop),
        .o_head  (n_head),
        .o_empty (n_q_empty),
        .o_full  (n_q_full)
    );

    lfhs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (n_q_empty),
        .i_head        (n_head),
        .o_pop         (n_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_pixel_index (o_pixel_index),
        .o_color_index (o_color_index),
        .o_frame_end   (o_frame_end)
    );

endmodule

// ===== bench/fire_checker.sv =====
// Watches both request channels and the register port of the fire block,
// predicts every cell result and compares it with what comes out.
module fire_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [7:0]         i_cool_draw,
    input  logic [7:0]         i_spark_chance_draw,
    input  logic [7:0]         i_spark_cell_draw,
    input  logic [7:0]         i_spark_heat_draw,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [7:0]         i_pixel_index,
    input  logic [7:0]         i_color_index,
    input  logic               i_frame_end,
    input  logic               i_cfg_we,
    input  lfhs_pkg::t_cfg_idx i_cfg_index,
    input  logic [8:0]         i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_checked,
    output int                 o_frames
);
    import lfhs_pkg::*;

    // Arithmetic of the heat simulation.
    localparam int SPAN_GAIN    = 10;
    localparam int SPAN_BIAS    = 2;
    localparam int HEAT_MAX     = 255;
    localparam int SPARK_SLOTS  = 7;
    localparam int SPARK_SPREAD = 95;
    localparam int SPARK_MIN    = 160;
    localparam int PALETTE_GAIN = 241;
    localparam int PRINT_CAP    = 50;

    typedef struct packed {
        logic [7:0] pixel;
        logic [7:0] color;
        logic       last;
    } t_fire_pixel;

    // Results still owed by the block, oldest first.
    t_fire_pixel expected_pixels[$];

    // Register copies.
    logic [7:0] cooling_cfg;
    logic [7:0] chance_cfg;
    logic [8:0] length_cfg;
    logic       reverse_cfg;

    // Simulation state.
    logic [7:0] heat_model [0:MAX_CELLS-1];
    logic [7:0] cell_pos;
    int         cooled_last;
    int         cooled_before;
    bit         spark_on;
    int         spark_at;
    int         spark_heat;

    int fail_total    = 0;
    int checked_total = 0;
    int frame_total   = 0;

    // Prints one line per mismatch, up to a cap, and counts all of them.
    task automatic report_mismatch(input string msg);
        fail_total++;
        if (fail_total <= PRINT_CAP) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    // Advances the heat simulation by one cell and returns its result.
    function automatic t_fire_pixel next_pixel(input logic [7:0] cd, ch, cl, ht);
        t_fire_pixel res;
        int len;
        int j;
        int old;
        int span;
        int cool;
        int cooled;
        int fresh;
        bit last;
        len = int'(length_cfg);
        if (len < LEN_MIN) len = LEN_MIN;
        if (len > LEN_MAX) len = LEN_MAX;
        j = int'(cell_pos);

        // The first cell of a frame decides the spark.
        if (j == 0) begin
            spark_on   = (ch < chance_cfg);
            spark_at   = (int'(cl) * SPARK_SLOTS) >> 8;
            spark_heat = SPARK_MIN + ((int'(ht) * SPARK_SPREAD) >> 8);
        end

        // Cool with saturation at zero.
        old  = int'(heat_model[j]);
        span = (int'(cooling_cfg) * SPAN_GAIN) / len + SPAN_BIAS;
        if (span > HEAT_MAX) span = HEAT_MAX;
        cool   = (int'(cd) * span) >> 8;
        cooled = (old > cool) ? old - cool : 0;

        // Diffuse from the two cells below; the bottom two keep their own heat.
        fresh = (j >= 2) ? (cooled_last + 2 * cooled_before) / 3 : cooled;

        if (spark_on && j == spark_at) begin
            fresh = fresh + spark_heat;
            if (fresh > HEAT_MAX) fresh = HEAT_MAX;
        end

        heat_model[j] = 8'(fresh);
        cooled_before = cooled_last;
        cooled_last   = cooled;

        last     = (j >= len - 1);
        cell_pos = last ? 8'd0 : 8'(j + 1);

        res.pixel = 8'(reverse_cfg ? (len - 1 - j) : j);
        res.color = 8'((fresh * PALETTE_GAIN) >> 8);
        res.last  = last;
        return res;
    endfunction

    // Predict on each accepted request, compare on each accepted result.
    always @(posedge i_clk) begin
        t_fire_pixel want;
        if (!i_rst_n) begin
            cooling_cfg   = COOLING_RST;
            chance_cfg    = CHANCE_RST;
            length_cfg    = LENGTH_RST;
            reverse_cfg   = 1'b0;
            for (int k = 0; k < MAX_CELLS; k++) heat_model[k] = 8'd0;
            cell_pos      = 8'd0;
            cooled_last   = 0;
            cooled_before = 0;
            spark_on      = 1'b0;
            spark_at      = 0;
            spark_heat    = 0;
            expected_pixels.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_COOLING: cooling_cfg = i_cfg_data[7:0];
                    CFG_CHANCE:  chance_cfg  = i_cfg_data[7:0];
                    CFG_LENGTH:  length_cfg  = i_cfg_data;
                    CFG_REVERSE: reverse_cfg = i_cfg_data[0];
                    default: ;
                endcase
            end

            if (i_in_valid && i_in_ready) begin
                expected_pixels.push_back(next_pixel(i_cool_draw, i_spark_chance_draw,
                                                     i_spark_cell_draw, i_spark_heat_draw));
            end

            if (i_out_valid && i_out_ready) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch($sformatf("result pixel %0d color %0d with no request waiting",
                                              i_pixel_index, i_color_index));
                end else begin
                    want = expected_pixels.pop_front();
                    if (i_pixel_index !== want.pixel) begin
                        report_mismatch($sformatf("result %0d pixel_index got %0d expected %0d",
                                                  checked_total, i_pixel_index, want.pixel));
                    end
                    if (i_color_index !== want.color) begin
                        report_mismatch($sformatf("result %0d color_index got %0d expected %0d",
                                                  checked_total, i_color_index, want.color));
                    end
                    if (i_frame_end !== want.last) begin
                        report_mismatch($sformatf("result %0d frame_end got %0b expected %0b",
                                                  checked_total, i_frame_end, want.last));
                    end
                end
                checked_total++;
                if (i_frame_end === 1'b1) frame_total++;
            end
        end
        o_pending    <= expected_pixels.size();
        o_fail_count <= fail_total;
        o_checked    <= checked_total;
        o_frames     <= frame_total;
    end

endmodule

// ===== bench/tb_led_fire_heat_simulation.sv =====
// Stimulus and verdict for the fire heat block; checking lives in fire_checker.
module tb_led_fire_heat_simulation;
    import lfhs_pkg::*;

    localparam int RANDOM_CELLS = 500;
    localparam int HOLD_CYCLES  = 100;
    localparam int SETTLE       = 8;
    localparam int STALL_LIMIT  = 4000;

    logic       i_clk               = 1'b0;
    logic       i_rst_n             = 1'b0;
    logic       i_in_valid          = 1'b0;
    logic [7:0] i_cool_draw         = 8'd0;
    logic [7:0] i_spark_chance_draw = 8'd0;
    logic [7:0] i_spark_cell_draw   = 8'd0;
    logic [7:0] i_spark_heat_draw   = 8'd0;
    logic       i_out_ready         = 1'b0;
    logic       i_cfg_we            = 1'b0;
    t_cfg_idx   i_cfg_index         = CFG_COOLING;
    logic [8:0] i_cfg_data          = 9'd0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_pixel_index;
    logic [7:0] o_color_index;
    logic       o_frame_end;

    int fail_count;
    int pending_cnt;
    int checked_cnt;
    int frame_cnt;

    int cells_sent    = 0;
    int settings_used = 0;
    int burst_left    = 0;
    int idle_cycles   = 0;
    bit hold_go       = 1'b0;
    bit hold_served   = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    led_fire_heat_simulation DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_cool_draw         (i_cool_draw),
        .i_spark_chance_draw (i_spark_chance_draw),
        .i_spark_cell_draw   (i_spark_cell_draw),
        .i_spark_heat_draw   (i_spark_heat_draw),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_pixel_index       (o_pixel_index),
        .o_color_index       (o_color_index),
        .o_frame_end         (o_frame_end),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    fire_checker fire_chk (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .i_in_ready          (o_in_ready),
        .i_cool_draw         (i_cool_draw),
        .i_spark_chance_draw (i_spark_chance_draw),
        .i_spark_cell_draw   (i_spark_cell_draw),
        .i_spark_heat_draw   (i_spark_heat_draw),
        .i_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .i_pixel_index       (o_pixel_index),
        .i_color_index       (o_color_index),
        .i_frame_end         (o_frame_end),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .o_fail_count        (fail_count),
        .o_pending           (pending_cnt),
        .o_checked           (checked_cnt),
        .o_frames            (frame_cnt)
    );

    // Offers one cell request and returns at the edge that accepts it.
    task automatic push_cell(input logic [7:0] cd, ch, cl, ht);
        i_in_valid          <= 1'b1;
        i_cool_draw         <= cd;
        i_spark_chance_draw <= ch;
        i_spark_cell_draw   <= cl;
        i_spark_heat_draw   <= ht;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        cells_sent++;
    endtask

    // Sends random cells in bursts with random gaps, or back to back when steady.
    task automatic offer_cells(input int count, input bit steady);
        int gap;
        for (int n = 0; n < count; n++) begin
            if (!steady && burst_left == 0) begin
                gap = $urandom_range(0, 6);
                if (gap != 0) begin
                    i_in_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                         : $urandom_range(1, 12);
            end
            if (burst_left != 0) burst_left--;
            push_cell(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end
    endtask

    // Lets every owed result come out, then a few more cycles.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_cnt != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [8:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    // Writes all four registers; the unused upper data bits are randomized.
    task automatic apply_setting(input logic [7:0] cool, chance, input logic [8:0] len,
                                 input logic rev);
        write_reg(CFG_COOLING, {1'($urandom_range(0, 1)), cool});
        write_reg(CFG_CHANCE,  {1'($urandom_range(0, 1)), chance});
        write_reg(CFG_LENGTH,  len);
        write_reg(CFG_REVERSE, {8'($urandom_range(0, 255)), rev});
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [7:0] pick_byte();
        logic [7:0] v;
        case ($urandom_range(0, 3))
            0:       v = 8'd0;
            1:       v = 8'd255;
            default: v = 8'($urandom_range(0, 255));
        endcase
        return v;
    endfunction

    // Receiver: stall patterns of random length, plus one long hold-off on request.
    initial begin : rx_side
        int seg_len;
        int stall_pct;
        @(posedge i_clk);
        forever begin
            seg_len = $urandom_range(1, 40);
            case ($urandom_range(0, 3))
                0:       stall_pct = 0;
                1:       stall_pct = 20;
                2:       stall_pct = 50;
                default: stall_pct = 80;
            endcase
            repeat (seg_len) begin
                if (hold_go && !hold_served) begin
                    hold_served = 1'b1;
                    i_out_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                end
                i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
                @(posedge i_clk);
            end
        end
    end

    // Watchdog on cycles where neither channel moves a request.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("watchdog: no request moved for %0d cycles", idle_cycles);
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int phase;
        int count;
        int sel;
        logic [8:0] len;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // Let the span divider finish its first run before the first register write.
        repeat (20) @(posedge i_clk);

        // Shortest strip with the strongest cooling, where the span saturates.
        apply_setting(8'd255, 8'd255, 9'd8, 1'b0);
        // Spark at the top of its range with the hottest heat draw.
        push_cell(8'h00, 8'h00, 8'hFF, 8'hFF);
        for (int k = 1; k < 8; k++) begin
            push_cell((k % 2) ? 8'hFF : 8'h00, (k % 2) ? 8'h00 : 8'hFF,
                      (k % 2) ? 8'h00 : 8'hFF, (k % 2) ? 8'hFF : 8'h00);
        end
        // Chance draw at its maximum never lights a spark.
        push_cell(8'hFF, 8'hFF, 8'h00, 8'h00);
        for (int k = 1; k < 8; k++) push_cell(8'hFF, 8'h00, 8'hFF, 8'h00);
        drain();

        // No cooling, reversed pixels, and a length below the minimum.
        apply_setting(8'd0, 8'd1, 9'd3, 1'b1);
        push_cell(8'h00, 8'h00, 8'h80, 8'h00);
        for (int k = 1; k < 8; k++) push_cell(8'h00, 8'hFF, 8'hFF, 8'hFF);
        drain();

        // Random settings; phases can end mid-frame, so lengths also change mid-frame.
        phase = 0;
        while (cells_sent < RANDOM_CELLS + 24) begin
            sel = $urandom_range(0, 9);
            case (sel)
                0:       len = 9'($urandom_range(0, 7));
                1:       len = 9'd8;
                2:       len = ($urandom_range(0, 1) != 0) ? 9'd256
                                                           : 9'($urandom_range(257, 511));
                default: len = 9'($urandom_range(9, 48));
            endcase
            apply_setting(pick_byte(), pick_byte(), len, 1'($urandom_range(0, 1)));
            if (phase == 1) begin
                // Long receiver hold-off while requests keep coming.
                hold_go = 1'b1;
                offer_cells(40, 1'b1);
            end else begin
                count = (sel == 2) ? $urandom_range(200, 280) : $urandom_range(10, 70);
                if (count > RANDOM_CELLS + 24 - cells_sent) begin
                    count = RANDOM_CELLS + 24 - cells_sent;
                end
                offer_cells(count, 1'b0);
            end
            drain();
            phase++;
        end

        $display("Run covered %0d cell results and %0d frame ends under %0d register settings,",
                 checked_cnt, frame_cnt, settings_used);
        $display("including clamped and mid-frame lengths, reversal and a long output stall.");
        if (fail_count == 0 && pending_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/lfhs_pkg.sv
rtl/core/lfhs_span_div.sv
rtl/core/lfhs_front.sv
rtl/core/lfhs_queue.sv
rtl/core/lfhs_back.sv
rtl/core/led_fire_heat_simulation.sv
bench/fire_checker.sv
bench/tb_led_fire_heat_simulation.sv
